// ===== rtl/core/tlwh_pkg.sv =====
// Shared constants and helpers for the text line wrap height estimator.
package tlwh_pkg;

  localparam int CP_W             = 21;
  localparam int WIDTH_W          = 24;
  localparam int HEIGHT_W         = 45;
  localparam int TOTAL_W          = 32;
  localparam int LINE_COUNT_WIDTH = 32;

  // Columns per line never exceed (2^24 - 1 - 24) / 8, which fits in 21 bits
  localparam int CPL_W  = 21;
  localparam int CPL2_W = CPL_W + 1;
  localparam int CPL4_W = CPL_W + 2;

  localparam logic [CP_W-1:0]     CP_NEWLINE     = CP_W'(32'h0a);
  localparam logic [CP_W-1:0]     CP_TAB         = CP_W'(32'h09);
  localparam logic [WIDTH_W-1:0]  VIEWPORT_RESET = WIDTH_W'(1024);
  localparam logic [WIDTH_W-1:0]  SIDE_PAD_PX    = WIDTH_W'(24);
  localparam logic [HEIGHT_W-1:0] PAD_Q8         = HEIGHT_W'(12 * 256);

  // max(1, floor((w - 24) / 8)), or 1 for widths of 24 and below
  function automatic logic [CPL_W-1:0] cols_per_line(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0] diff;
    logic [CPL_W-1:0]   cols;
    diff = w - SIDE_PAD_PX;
    cols = diff[WIDTH_W-1:3];
    if (w <= SIDE_PAD_PX || cols == '0) begin
      cols = CPL_W'(1);
    end
    return cols;
  endfunction

  // padding plus lines times 18 px line height, all Q8: 4608 = 4096 + 512
  function automatic logic [HEIGHT_W-1:0] height_of(input logic [TOTAL_W-1:0] lines);
    logic [HEIGHT_W-1:0] ext;
    ext = HEIGHT_W'(lines);
    return PAD_Q8 + (ext << 12) + (ext << 9);
  endfunction

endpackage

// ===== rtl/core/tlwh_in_if.sv =====
// Input channel: one code point word with its run markers.
interface tlwh_in_if import tlwh_pkg::*;;
  logic            valid;
  logic            ready;
  logic [CP_W-1:0] code_point;
  logic            is_flush;
  logic            last;

  modport source (output valid, output code_point, output is_flush, output last,
                  input ready);
  modport sink   (input valid, input code_point, input is_flush, input last,
                  output ready);
endinterface

// ===== rtl/core/tlwh_out_if.sv =====
// Result channel: line count and rendered height of one run.
interface tlwh_out_if import tlwh_pkg::*;;
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] render_height;
  logic [TOTAL_W-1:0]  line_tally;

  modport source (output valid, output render_height, output line_tally, input ready);
  modport sink   (input valid, input render_height, input line_tally, output ready);
endinterface

// ===== rtl/core/text_line_wrap_height_estimator.sv =====
// Text line wrap height estimator. Takes one code point word per cycle and keeps
// the line and column count of the current run; a word with last or is_flush set
// closes the run, and its result (line_tally, render_height = 3072 + lines * 4608)
// is registered in the closed-run register (fin_valid, fin_lines), then moves into
// the result register once any earlier result is taken. Throughput is
// one word per cycle: the column update is a set of parallel compares against
// stored multiples of the columns per line, and ready only drops when a closed
// run waits behind a result that the sink has not yet taken. A viewport write
// takes effect for the next word.
module text_line_wrap_height_estimator import tlwh_pkg::*; #(
  parameter int LineCountWidth = LINE_COUNT_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [WIDTH_W-1:0]  cfg_wr_data,
  tlwh_in_if.sink             text_in,
  tlwh_out_if.source          result_out
);

  localparam int LW    = LineCountWidth;
  localparam int EXT_W = (LW > TOTAL_W) ? LW : TOTAL_W;

  // columns per line and its multiples, loaded with the viewport width
  logic [CPL_W-1:0]  cpl;
  logic [CPL2_W-1:0] cpl2;
  logic [CPL4_W-1:0] cpl3;
  logic [CPL4_W-1:0] cpl4;
  logic [CPL_W-1:0]  cfg_cpl;

  // run state
  logic [LW-1:0]     lines;
  logic [CPL_W-1:0]  col;
  logic              has_char;

  // closed run waiting for the result stage
  logic              fin_valid;
  logic [LW-1:0]     fin_lines;
  logic              fin_add_one;

  logic              in_fire;
  logic              run_end;
  logic              fin_move;

  logic [CPL_W-1:0]  col_step;
  logic [CPL4_W-1:0] col_ext;
  logic [2:0]        wraps;
  logic [2:0]        line_adds;
  logic [CPL4_W-1:0] col_sub;
  logic [CPL_W-1:0]  col_next;
  logic [LW:0]       lines_sum;
  logic [LW-1:0]     lines_next;
  logic              has_char_next;

  logic [LW:0]       total_sum;
  logic [LW-1:0]     total_sat;
  logic [EXT_W-1:0]  total_ext;
  logic [TOTAL_W-1:0] total_clamp;

  assign cfg_cpl = cols_per_line(cfg_wr_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      cpl  <= cols_per_line(VIEWPORT_RESET);
      cpl2 <= {cols_per_line(VIEWPORT_RESET), 1'b0};
      cpl3 <= CPL4_W'({cols_per_line(VIEWPORT_RESET), 1'b0})
              + CPL4_W'(cols_per_line(VIEWPORT_RESET));
      cpl4 <= {cols_per_line(VIEWPORT_RESET), 2'b00};
    end else if (cfg_wr_en) begin
      cpl  <= cfg_cpl;
      cpl2 <= {cfg_cpl, 1'b0};
      cpl3 <= CPL4_W'({cfg_cpl, 1'b0}) + CPL4_W'(cfg_cpl);
      cpl4 <= {cfg_cpl, 2'b00};
    end
  end

  assign fin_move      = fin_valid && (!result_out.valid || result_out.ready);
  assign text_in.ready = !fin_valid || fin_move;
  assign in_fire       = text_in.valid && text_in.ready;
  assign run_end       = text_in.is_flush || text_in.last;

  // column advance and wrap count; with the column below cpl there are at most four wraps
  always_comb begin
    col_step = col + ((text_in.code_point == CP_TAB) ? CPL_W'(4) : CPL_W'(1));
    col_ext  = CPL4_W'(col_step);
    if (col_ext >= cpl4) begin
      wraps   = 3'd4;
      col_sub = cpl4;
    end else if (col_ext >= cpl3) begin
      wraps   = 3'd3;
      col_sub = cpl3;
    end else if (col_ext >= CPL4_W'(cpl2)) begin
      wraps   = 3'd2;
      col_sub = CPL4_W'(cpl2);
    end else if (col_ext >= CPL4_W'(cpl)) begin
      wraps   = 3'd1;
      col_sub = CPL4_W'(cpl);
    end else begin
      wraps   = 3'd0;
      col_sub = '0;
    end

    if (text_in.is_flush) begin
      line_adds = 3'd0;
      col_next  = col;
    end else if (text_in.code_point == CP_NEWLINE) begin
      line_adds = 3'd1;
      col_next  = '0;
    end else begin
      line_adds = wraps;
      col_next  = CPL_W'(col_ext - col_sub);
    end

    // saturate the line count at its top value
    lines_sum     = {1'b0, lines} + (LW+1)'(line_adds);
    lines_next    = lines_sum[LW] ? '1 : lines_sum[LW-1:0];
    has_char_next = has_char || !text_in.is_flush;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lines    <= '0;
      col      <= '0;
      has_char <= 1'b0;
    end else if (in_fire) begin
      if (run_end) begin
        lines    <= '0;
        col      <= '0;
        has_char <= 1'b0;
      end else begin
        lines    <= lines_next;
        col      <= col_next;
        has_char <= has_char_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (in_fire && run_end) begin
      fin_valid <= 1'b1;
    end else if (fin_move) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && run_end) begin
      fin_lines   <= lines_next;
      fin_add_one <= (col_next != '0) || !has_char_next;
    end
  end

  // final line count: add the open line, saturate, clamp to the port width
  always_comb begin
    total_sum   = {1'b0, fin_lines} + (LW+1)'(fin_add_one);
    total_sat   = total_sum[LW] ? '1 : total_sum[LW-1:0];
    total_ext   = EXT_W'(total_sat);
    total_clamp = ((total_ext >> TOTAL_W) != '0) ? '1 : total_ext[TOTAL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (fin_move) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_move) begin
      result_out.line_tally    <= total_clamp;
      result_out.render_height <= height_of(total_clamp);
    end
  end

  // the column is reduced below the columns per line; a viewport write that narrows the line mid-run can break this
  assert property (@(posedge clk) disable iff (rst) col < cpl)
    else $error("column count not below columns per line");

  // a result word always matches its line count
  assert property (@(posedge clk) disable iff (rst)
    result_out.valid |-> result_out.render_height == height_of(result_out.line_tally))
    else $error("height does not match line count");

  // a held result keeps a closed run waiting
  assert property (@(posedge clk) disable iff (rst)
    fin_valid && result_out.valid && !result_out.ready |=> fin_valid)
    else $error("closed run dropped while result stalled");

  // a word that does not close the run never produces a closed run
  assert property (@(posedge clk) disable iff (rst)
    !fin_valid && !(in_fire && run_end) |=> !fin_valid)
    else $error("closed run appeared without a closing word");

  // the doubled and quadrupled multiples track the base value
  assert property (@(posedge clk) disable iff (rst)
    cpl4 == {cpl, 2'b00} && cpl2 == {cpl, 1'b0})
    else $error("column multiples out of step");

endmodule
